FILE: design/cft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants of the checksum frame transmitter.
// ----------------------------------------------------------------------------
package cft_pkg;

   localparam int unsigned HEADER_OVERHEAD = 4;
   localparam int unsigned MAX_PAYLOAD     = 255;
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   // register index decoded from paddr
   typedef enum logic [0:0] {
      CSR_FRAME_ID    = 1'b0,
      CSR_PAYLOAD_LEN = 1'b1
   } cft_csr_type;

   // position of a word inside the full frame sequence of one input
   typedef enum logic [2:0] {
      POS_ID     = 3'd0,
      POS_LEN_LO = 3'd1,
      POS_LEN_HI = 3'd2,
      POS_DATA   = 3'd3,
      POS_CSUM   = 3'd4
   } cft_pos_type;

   typedef struct packed {
      logic [7:0] frame_id;
      logic [7:0] payload_len;
   } cft_cfg_type;

   typedef struct packed {
      logic       first;
      logic       last;
      logic [7:0] frame_id;
      logic [7:0] len_lo;
      logic [7:0] len_hi;
      logic [7:0] data;
      logic [7:0] csum;
   } cft_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cft_qstat_type;

endpackage
`default_nettype wire

FILE: design/checksum_frame_transmitter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// checksum_frame_transmitter_core
// Length-prefixed framer with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// The first word of an input passes the job queue, then the output register.
// The back end sends one output word per cycle unless rsp_stall holds it; an
// input yields a data word, led by three header words if first in its frame,
// trailed by the checksum word if last. A two-entry job queue lets inputs
// arrive back to back while words drain. Reset (synchronous): counters and
// sum clear, frame_id=0, payload_len=1, queue and output register empty.
module checksum_frame_transmitter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_payload_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic             rsp_run_end,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import cft_pkg::*;

   cft_cfg_type   cfg;
   cft_job_type   push_job;
   cft_job_type   head;
   cft_qstat_type qstat;
   logic          push;
   logic          pop;

   cft_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cft_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .cfg              (cfg),
      .qstat            (qstat),
      .push             (push),
      .job              (push_job)
   );

   cft_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   cft_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .qstat         (qstat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end),
      .rsp_run_end   (rsp_run_end)
   );

`ifndef SYNTHESIS
   // checksum word is always the last word of its input
   a_csum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_run_end)
      else $error("checksum word not marked as run end");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("job queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("pop from empty job queue");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && qstat.empty)
      else $error("output or queue not clear after reset");
`endif

endmodule
`default_nettype wire

FILE: design/cft_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cft_csr
// APB-style register file: frame id and payload length.
// ----------------------------------------------------------------------------
module cft_csr (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [2:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready,
   output cft_pkg::cft_cfg_type      cfg
);
   import cft_pkg::*;

   logic [7:0]  frame_id_ff, frame_id_in;
   logic [7:0]  payload_len_ff, payload_len_in;
   logic        wr_en;
   cft_csr_type sel;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign sel    = cft_csr_type'(paddr[2]);

   always_comb begin
      frame_id_in    = frame_id_ff;
      payload_len_in = payload_len_ff;
      if (wr_en) begin
         case (sel)
            CSR_FRAME_ID:    frame_id_in    = pwdata[7:0];
            CSR_PAYLOAD_LEN: payload_len_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_id_ff    <= 8'd0;
         payload_len_ff <= 8'd1;
      end else begin
         frame_id_ff    <= frame_id_in;
         payload_len_ff <= payload_len_in;
      end
   end

   always_comb begin
      case (sel)
         CSR_FRAME_ID:    prdata = {24'd0, frame_id_ff};
         CSR_PAYLOAD_LEN: prdata = {24'd0, payload_len_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg.frame_id    = frame_id_ff;
   assign cfg.payload_len = payload_len_ff;

endmodule
`default_nettype wire

FILE: design/cft_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cft_front
// Takes payload words, tracks frame position and running sum, and builds
// one job per word (header, data and checksum bytes it must emit).
// ----------------------------------------------------------------------------
module cft_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_payload_byte,
   input  wire cft_pkg::cft_cfg_type cfg,
   input  wire cft_pkg::cft_qstat_type qstat,
   output logic                      push,
   output cft_pkg::cft_job_type      job
);
   import cft_pkg::*;

   logic [7:0] index_ff, index_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] eff_len;
   logic [8:0] total;
   logic [8:0] next_count;
   logic [7:0] base;
   logic [7:0] sum_after;
   logic       first;
   logic       last;

   assign req_stall = qstat.full;
   assign push      = req_valid & ~qstat.full;

   always_comb begin
      eff_len = (cfg.payload_len == 8'd0) ? 8'd1 : cfg.payload_len;
      if (9'(eff_len) > 9'(MAX_PAYLOAD))
         eff_len = 8'(MAX_PAYLOAD);
   end

   assign total      = 9'(eff_len) + 9'(HEADER_OVERHEAD);
   assign first      = (index_ff == 8'd0);
   assign next_count = 9'(index_ff) + 9'd1;
   assign last       = (next_count >= 9'(eff_len));

   // header bytes count toward the checksum on the first word
   assign base      = first ? (cfg.frame_id + total[7:0] + {7'd0, total[8]}) : sum_ff;
   assign sum_after = base + req_payload_byte;

   assign job.first    = first;
   assign job.last     = last;
   assign job.frame_id = cfg.frame_id;
   assign job.len_lo   = total[7:0];
   assign job.len_hi   = {7'd0, total[8]};
   assign job.data     = req_payload_byte;
   assign job.csum     = sum_after;

   always_comb begin
      index_in = index_ff;
      sum_in   = sum_ff;
      if (push) begin
         index_in = last ? 8'd0 : next_count[7:0];
         sum_in   = last ? 8'd0 : sum_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 8'd0;
         sum_ff   <= 8'd0;
      end else begin
         index_ff <= index_in;
         sum_ff   <= sum_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/cft_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cft_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module cft_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cft_pkg::cft_job_type push_job,
   input  wire logic                 pop,
   output cft_pkg::cft_job_type      head,
   output cft_pkg::cft_qstat_type    qstat
);
   import cft_pkg::*;

   cft_job_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
      return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   assign qstat.full  = (32'(count_ff) == QUEUE_DEPTH);
   assign qstat.empty = (count_ff == '0);
   assign head        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule
`default_nettype wire

FILE: design/cft_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cft_back
// Expands each queued job into its frame words and loads them into the
// output register, one per cycle while rsp_stall does not hold it.
// ----------------------------------------------------------------------------
module cft_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cft_pkg::cft_job_type   head,
   input  wire cft_pkg::cft_qstat_type qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_frame_end,
   output logic                        rsp_run_end
);
   import cft_pkg::*;

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        fend_ff, fend_in;
   logic        rend_ff, rend_in;
   logic [2:0]  pos_ff, pos_in;
   logic        load;
   logic        job_done;
   cft_pos_type q;
   cft_pos_type q_last;

   assign load   = ~valid_ff | ~rsp_stall;
   // jobs without header start at the data word
   assign q      = cft_pos_type'(head.first ? pos_ff : pos_ff + 3'd3);
   assign q_last = head.last ? POS_CSUM : POS_DATA;
   assign job_done = (q == q_last);
   assign pop    = load & ~qstat.empty & job_done;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      fend_in  = fend_ff;
      rend_in  = rend_ff;
      pos_in   = pos_ff;
      if (load) begin
         valid_in = ~qstat.empty;
         if (!qstat.empty) begin
            fend_in = (q == POS_CSUM);
            rend_in = job_done;
            pos_in  = job_done ? 3'd0 : pos_ff + 3'd1;
            case (q)
               POS_ID:     byte_in = head.frame_id;
               POS_LEN_LO: byte_in = head.len_lo;
               POS_LEN_HI: byte_in = head.len_hi;
               POS_DATA:   byte_in = head.data;
               POS_CSUM:   byte_in = head.csum;
               default:    byte_in = 8'd0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      fend_ff <= fend_in;
      rend_ff <= rend_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = fend_ff;
   assign rsp_run_end   = rend_ff;

endmodule
`default_nettype wire

FILE: bench/checksum_frame_transmitter_core_tb.sv
// ----------------------------------------------------------------------------
// checksum_frame_transmitter_core_tb
// Self-checking bench for the length-prefixed checksum framer: payload bytes
// go in, every frame word coming out is compared against a local model of the
// header, payload and checksum sequence, under several idle/stall profiles.
// ----------------------------------------------------------------------------
module checksum_frame_transmitter_core_tb;
   import cft_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int BATCH_ITEMS    = 30;

   typedef struct {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_end;
   } frame_word_type;

   // model of the framer plus the queue of words it still owes
   class frame_scoreboard;
      frame_word_type owed_words[$];
      logic [7:0]  id_reg;
      logic [7:0]  len_reg;
      logic [7:0]  byte_count;
      logic [7:0]  csum;
      int          errors;
      int          bytes_in;
      int          words_out;

      function new();
         id_reg     = 8'd0;
         len_reg    = 8'd1;
         byte_count = 8'd0;
         csum       = 8'd0;
         errors     = 0;
         bytes_in   = 0;
         words_out  = 0;
      endfunction

      function void write_reg(cft_csr_type idx, logic [31:0] value);
         case (idx)
            CSR_FRAME_ID:    id_reg  = value[7:0];
            CSR_PAYLOAD_LEN: len_reg = value[7:0];
            default: ;
         endcase
      endfunction

      function void owe(logic [7:0] b, logic fend, logic rend);
         frame_word_type w;
         w.out_byte  = b;
         w.frame_end = fend;
         w.run_end   = rend;
         owed_words.push_back(w);
         csum = csum + b;
      endfunction

      function void note_input(logic [7:0] b);
         int          eff;
         logic [15:0] total;
         logic        closes;
         eff = (len_reg == 8'd0) ? 1 : int'(len_reg);
         if (eff > MAX_PAYLOAD) eff = MAX_PAYLOAD;
         bytes_in++;
         if (byte_count == 8'd0) begin
            csum  = 8'd0;
            total = 16'(eff + HEADER_OVERHEAD);
            owe(id_reg, 1'b0, 1'b0);
            owe(total[7:0], 1'b0, 1'b0);
            owe(total[15:8], 1'b0, 1'b0);
         end
         // a length lowered mid-frame closes on the first byte at or past it
         closes = (int'(byte_count) + 1 >= eff);
         owe(b, 1'b0, !closes);
         if (closes) begin
            owe(csum, 1'b1, 1'b1);
            byte_count = 8'd0;
            csum       = 8'd0;
         end else begin
            byte_count = byte_count + 8'd1;
         end
      endfunction

      function void check_word(logic [7:0] ob, logic fend, logic rend);
         frame_word_type w;
         words_out++;
         if (owed_words.size() == 0) begin
            $error("unexpected word: out_byte %0h frame_end %0b run_end %0b", ob, fend, rend);
            errors++;
         end else begin
            w = owed_words.pop_front();
            if (ob !== w.out_byte) begin
               $error("out_byte: expected %0h, got %0h", w.out_byte, ob);
               errors++;
            end
            if (fend !== w.frame_end) begin
               $error("frame_end: expected %0b, got %0b", w.frame_end, fend);
               errors++;
            end
            if (rend !== w.run_end) begin
               $error("run_end: expected %0b, got %0b", w.run_end, rend);
               errors++;
            end
         end
      endfunction

      function int pending();
         return owed_words.size();
      endfunction
   endclass

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [7:0]  req_payload_byte = 8'd0;
   logic        rsp_stall        = 1'b1;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [2:0]  paddr            = 3'd0;
   logic [31:0] pwdata           = 32'd0;
   wire         req_stall;
   wire         rsp_valid;
   wire  [7:0]  rsp_out_byte;
   wire         rsp_frame_end;
   wire         rsp_run_end;
   wire  [31:0] prdata;
   wire         pready;

   int src_idle  = 0;
   int sink_idle = 0;
   int quiet_cycles = 0;

   frame_scoreboard sb = new();

   checksum_frame_transmitter_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_run_end      (rsp_run_end),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check accepted words, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_out_byte, rsp_frame_end, rsp_run_end);
      rsp_stall <= ($urandom_range(99) < sink_idle);
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words outstanding", sb.pending());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (src_idle > 0 && $urandom_range(99) < src_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(b);
   endtask

   task automatic stop_sending();
      req_valid        <= 1'b0;
      req_payload_byte <= 8'($urandom_range(255));
      @(posedge clock);
   endtask

   // let every owed word drain, then idle before returning
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input cft_csr_type idx, input logic [7:0] value);
      logic [31:0] wdata;
      wdata      = $urandom();
      wdata[7:0] = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.write_reg(idx, wdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] id, input logic [7:0] len);
      wait_drained();
      csr_write(CSR_FRAME_ID, id);
      csr_write(CSR_PAYLOAD_LEN, len);
   endtask

   function automatic logic [7:0] pick_len();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd254;
         default: return 8'($urandom_range(1, 9));
      endcase
   endfunction

   task automatic random_phase(input int s_idle, input int r_idle);
      src_idle  = s_idle;
      sink_idle = r_idle;
      for (int s = 0; s < 4; s++) begin
         // registers change mid-frame more often than not
         configure(8'($urandom_range(255)), pick_len());
         for (int i = 0; i < BATCH_ITEMS; i++)
            send_byte(8'($urandom_range(255)));
         stop_sending();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults give one-byte frames
      src_idle  = 20;
      sink_idle = 30;
      send_byte(8'h00);
      send_byte(8'hFF);
      stop_sending();
      // zero length acts as one
      configure(8'hFF, 8'd0);
      send_byte(8'hA5);
      stop_sending();
      configure(8'h5A, 8'd2);
      send_byte(8'hFF);
      send_byte(8'hFF);
      stop_sending();
      // longest length, then cut short mid-frame
      configure(8'h00, 8'd255);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'h7F);
      stop_sending();
      configure(8'h00, 8'd3);
      send_byte(8'hC3);
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      stop_sending();
      // length raised mid-frame: header keeps the old value
      configure(8'h96, 8'd2);
      send_byte(8'h44);
      stop_sending();
      configure(8'h96, 8'd4);
      send_byte(8'h55);
      send_byte(8'h66);
      send_byte(8'h77);
      stop_sending();

      random_phase(36, 82);
      random_phase(82, 36);
      random_phase(0, 0);

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d payload bytes and %0d frame words", sb.bytes_in, sb.words_out);
      $display("three idle profiles, lengths 0 to 255, mid-frame length changes");
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
